/* src/assert_macros.svh */
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define IVS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be true outside reset
`define IVS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define IVS_ASSERT(lbl, clk, rst_n, prop, msg)

`define IVS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

/* src/ivs_pkg.sv */
// types, constants and gain table for the i-v sweep averager
package ivs_pkg;

  localparam int unsigned GATE_W     = 16;
  localparam int unsigned AVG_W      = 8;
  localparam int unsigned RANGE_W    = 2;
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned VOUT_W     = 24;
  localparam int unsigned IOUT_W     = 20;
  localparam int unsigned POUT_W     = 26;
  localparam int unsigned GAIN_W     = 23;
  localparam int unsigned MUL_A_W    = 24;
  localparam int unsigned MUL_B_W    = 20;
  localparam int unsigned PROD_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FRAC_W     = 16;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [MUL_B_W-1:0] IGAIN_Q16 = 20'd531949;
  localparam logic [IOUT_W-1:0]  IOFFS_Q16 = 20'd918;
  localparam logic [PROD_W-1:0]  PWR_RND   = 44'd32768;

  localparam logic [AVG_W-1:0]   AVG_RST   = 8'd25;
  localparam logic [GATE_W-1:0]  START_RST = 16'd19661;
  localparam logic [GATE_W-1:0]  STOP_RST  = 16'd29491;
  localparam logic [GATE_W-1:0]  STEP_RST  = 16'd7;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE = 3'd0,
    REG_AVG   = 3'd1,
    REG_START = 3'd2,
    REG_STOP  = 3'd3,
    REG_STEP  = 3'd4
  } cfg_reg_e;

  // sweep phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_FWD  = 2'd1,
    PH_BWD  = 2'd2
  } phase_e;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [RANGE_W-1:0] range_mode;
    logic [AVG_W-1:0]   avg;
    logic [GATE_W-1:0]  gate_start;
    logic [GATE_W-1:0]  gate_stop;
    logic [GATE_W-1:0]  gate_step;
  } cfg_t;

  // one result beat
  typedef struct packed {
    logic [GATE_W-1:0] dac_code;
    logic              point_valid;
    logic [GATE_W-1:0] point_gate;
    logic [VOUT_W-1:0] voltage;
    logic [IOUT_W-1:0] current;
    logic [POUT_W-1:0] power;
    logic              sweep_down;
    logic              scan_done;
    logic              scanning;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic mul_v;
    logic div_start;
    logic take_v;
    logic mul_i;
    logic take_i;
    logic mul_p;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic point_due;
    logic div_done;
  } dp_sts_t;

  // voltage gain in q.16, ranges two and three use the array gain
  function automatic logic [GAIN_W-1:0] vgain(input logic [RANGE_W-1:0] rng);
    logic [GAIN_W-1:0] g;
    case (rng)
      2'd0:    g = 23'd72398;
      2'd1:    g = 23'd357768;
      default: g = 23'd7328544;
    endcase
    return g;
  endfunction

endpackage

/* src/ivs_div.sv */
// restoring divider, one quotient bit per cycle, 8-bit divisor
module ivs_div
  import ivs_pkg::*;
#(
  parameter int unsigned QW = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QW-1:0]    numer_i,
  input  logic [AVG_W-1:0] denom_i,
  output logic [QW-1:0]    quot_o,
  output logic             done_o
);

  localparam int unsigned CW = $clog2(QW);

  logic [QW-1:0]    a_q, a_d;
  logic [AVG_W-1:0] rem_q, rem_d;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [AVG_W:0]   trial, diff;
  logic             ge;
  logic             last;

  // one shift-subtract step
  always_comb begin
    trial = {rem_q, a_q[QW-1]};
    diff  = trial - {1'b0, denom_i};
    ge    = trial >= {1'b0, denom_i};
    rem_d = ge ? diff[AVG_W-1:0] : trial[AVG_W-1:0];
    a_d   = {a_q[QW-2:0], ge};
    last  = cnt_q == CW'(QW - 1);
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= numer_i;
      rem_q <= '0;
    end else if (busy_q) begin
      a_q   <= a_d;
      rem_q <= rem_d;
    end
  end

  assign quot_o = a_q;
  assign done_o = done_q;

endmodule

/* src/ivs_dp.sv */
// datapath: sweep state, sums, shared multiplier, divider and result register
module ivs_dp
  import ivs_pkg::*;
#(
  parameter int unsigned ADC_BITS = 12,
  parameter int unsigned DAC_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  dp_cmd_t             cmd_i,
  input  logic                opcode_i,
  input  logic [ADC_BITS-1:0] voltage_sample_i,
  input  logic [ADC_BITS-1:0] current_sample_i,
  output dp_sts_t             sts_o,
  output res_t                res_o
);

  localparam int unsigned QW = PROD_W - ADC_BITS;
  localparam logic [GATE_W-1:0] DAC_MASK = GATE_W'({GATE_W{1'b1}} << (GATE_W - DAC_BITS));

  // captured input beat
  logic                op_q;
  logic [ADC_BITS-1:0] vs_q, cs_q;

  // sweep state
  phase_e            phase_q, phase_d;
  logic [GATE_W-1:0] gate_q, gate_d;
  logic [AVG_W-1:0]  pcnt_q, pcnt_d;
  logic [SUM_W-1:0]  vsum_q, vsum_d, isum_q, isum_d;

  // arithmetic registers
  logic [PROD_W-1:0] prod_q;
  logic [VOUT_W-1:0] v_q;
  logic [IOUT_W-1:0] i_q;
  res_t              res_q, res_d;

  logic              active;
  logic [AVG_W-1:0]  pc1;
  logic [SUM_W:0]    vadd, iadd;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0] rnd, numer_full;
  logic [QW-1:0]     quot;
  logic              div_done;
  logic [QW:0]       i_full;
  logic [PROD_W-1:0] p_sum;
  logic [POUT_W-1:0] p_sat;
  logic [GATE_W:0]   nxt, lim;

  // status for the controller
  always_comb begin
    active = (phase_q == PH_FWD) || (phase_q == PH_BWD);
    pc1    = pcnt_q + 1'b1;
    vadd   = {1'b0, vsum_q} + (SUM_W + 1)'(vs_q);
    iadd   = {1'b0, isum_q} + (SUM_W + 1)'(cs_q);
    sts_o.point_due = op_q && active && ((pc1 == '0) || (pc1 >= cfg_i.avg));
    sts_o.div_done  = div_done;
  end

  // shared multiplier operand select
  always_comb begin
    if (cmd_i.mul_v) begin
      mul_a = MUL_A_W'(vgain(cfg_i.range_mode));
      mul_b = vsum_q;
    end else if (cmd_i.mul_i) begin
      mul_a = MUL_A_W'(IGAIN_Q16);
      mul_b = isum_q;
    end else begin
      mul_a = v_q;
      mul_b = i_q;
    end
    mul_p = mul_a * mul_b;
  end

  // divider: (prod + avg*2^(adc-1)) >> adc, then / avg
  always_comb begin
    rnd        = PROD_W'(cfg_i.avg) << (ADC_BITS - 1);
    numer_full = (prod_q + rnd) >> ADC_BITS;
  end

  ivs_div #(
    .QW(QW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .numer_i (numer_full[QW-1:0]),
    .denom_i (cfg_i.avg),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  // current offset, power rounding with saturation, and the next and limit gate codes
  always_comb begin
    i_full = (QW + 1)'(quot) + (QW + 1)'(IOFFS_Q16);
    p_sum  = prod_q + PWR_RND;
    p_sat  = (p_sum[PROD_W-1:FRAC_W+POUT_W] != '0) ? {POUT_W{1'b1}}
                                                    : p_sum[FRAC_W+POUT_W-1:FRAC_W];
    nxt    = {1'b0, gate_q} + {1'b0, cfg_i.gate_step};
    lim    = {1'b0, cfg_i.gate_start} + {1'b0, cfg_i.gate_step};
  end

  // sweep state update and result build
  always_comb begin
    phase_d = phase_q;
    gate_d  = gate_q;
    pcnt_d  = pcnt_q;
    vsum_d  = vsum_q;
    isum_d  = isum_q;
    res_d   = res_q;
    if (cmd_i.step) begin
      res_d = '0;
      if (!op_q) begin
        pcnt_d  = '0;
        vsum_d  = '0;
        isum_d  = '0;
        gate_d  = cfg_i.gate_start;
        phase_d = (cfg_i.gate_start <= cfg_i.gate_stop) ? PH_FWD : PH_IDLE;
        res_d.dac_code = cfg_i.gate_start & DAC_MASK;
        res_d.scanning = cfg_i.gate_start <= cfg_i.gate_stop;
      end else if (!active) begin
        res_d.dac_code = gate_q & DAC_MASK;
      end else begin
        vsum_d = vadd[SUM_W] ? SUM_MAX : vadd[SUM_W-1:0];
        isum_d = iadd[SUM_W] ? SUM_MAX : iadd[SUM_W-1:0];
        pcnt_d = pc1;
        res_d.dac_code = gate_q & DAC_MASK;
        res_d.scanning = 1'b1;
      end
    end else if (cmd_i.finish) begin
      res_d             = '0;
      res_d.point_valid = 1'b1;
      res_d.point_gate  = gate_q;
      res_d.voltage     = v_q;
      res_d.current     = i_q;
      res_d.power       = p_sat;
      res_d.sweep_down  = phase_q == PH_BWD;
      if (phase_q != PH_BWD) begin
        if (nxt > {1'b0, cfg_i.gate_stop}) begin
          phase_d = PH_BWD;
          gate_d  = cfg_i.gate_stop;
        end else begin
          gate_d = nxt[GATE_W-1:0];
        end
      end else begin
        if ({1'b0, gate_q} < lim) begin
          phase_d         = PH_IDLE;
          res_d.scan_done = 1'b1;
        end else begin
          gate_d = gate_q - cfg_i.gate_step;
        end
      end
      pcnt_d = '0;
      vsum_d = '0;
      isum_d = '0;
      res_d.dac_code = gate_d & DAC_MASK;
      res_d.scanning = phase_d != PH_IDLE;
    end
  end

  // sweep state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      gate_q  <= '0;
      pcnt_q  <= '0;
      vsum_q  <= '0;
      isum_q  <= '0;
    end else begin
      phase_q <= phase_d;
      gate_q  <= gate_d;
      pcnt_q  <= pcnt_d;
      vsum_q  <= vsum_d;
      isum_q  <= isum_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= opcode_i;
      vs_q <= voltage_sample_i;
      cs_q <= current_sample_i;
    end
    if (cmd_i.mul_v || cmd_i.mul_i || cmd_i.mul_p) begin
      prod_q <= mul_p;
    end
    if (cmd_i.take_v) begin
      v_q <= (quot[QW-1:VOUT_W] != '0) ? {VOUT_W{1'b1}} : quot[VOUT_W-1:0];
    end
    if (cmd_i.take_i) begin
      i_q <= (i_full[QW:IOUT_W] != '0) ? {IOUT_W{1'b1}} : i_full[IOUT_W-1:0];
    end
    res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

/* src/ivs_ctrl.sv */
// controller: sequences capture, accumulate, scaling and result hand-off
module ivs_ctrl
  import ivs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  logic    out_free_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    in_ready_o,
  output logic    load_out_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_STEP  = 11'b000_0000_0010,
    S_MULV  = 11'b000_0000_0100,
    S_DIVV  = 11'b000_0000_1000,
    S_WAITV = 11'b000_0001_0000,
    S_MULI  = 11'b000_0010_0000,
    S_DIVI  = 11'b000_0100_0000,
    S_WAITI = 11'b000_1000_0000,
    S_PWR   = 11'b001_0000_0000,
    S_FIN   = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    load_out_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_fire_i;
        if (in_fire_i) state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.step = 1'b1;
        state_d    = sts_i.point_due ? S_MULV : S_EMIT;
      end
      S_MULV: begin
        cmd_o.mul_v = 1'b1;
        state_d     = S_DIVV;
      end
      S_DIVV: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAITV;
      end
      S_WAITV: begin
        cmd_o.take_v = sts_i.div_done;
        if (sts_i.div_done) state_d = S_MULI;
      end
      S_MULI: begin
        cmd_o.mul_i = 1'b1;
        state_d     = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_WAITI;
      end
      S_WAITI: begin
        cmd_o.take_i = sts_i.div_done;
        if (sts_i.div_done) state_d = S_PWR;
      end
      S_PWR: begin
        cmd_o.mul_p = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        load_out_o = out_free_i;
        if (out_free_i) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/iv_curve_sweep_averager_unit.sv */
// i-v curve sweep averager top level: config registers, controller, datapath, output register
// a start beat or a sample that completes no point goes from the step state straight to the emit state
// a completing sample then goes through the scaling states, which hold two
// passes through the bit-serial divider that divides the scaled sums by avg_count
// one item is in work at a time; the next beat is taken while the last result waits downstream
// reset clears the sweep state to idle and loads the register defaults; no clearing pass
`include "assert_macros.svh"

module iv_curve_sweep_averager_unit
  import ivs_pkg::*;
#(
  parameter int unsigned ADC_BITS = 12,
  parameter int unsigned DAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic [ADC_BITS-1:0]   voltage_sample_i,
  input  logic [ADC_BITS-1:0]   current_sample_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [GATE_W-1:0]     dac_code_o,
  output logic                  point_valid_o,
  output logic [GATE_W-1:0]     point_gate_o,
  output logic [VOUT_W-1:0]     voltage_out_o,
  output logic [IOUT_W-1:0]     current_out_o,
  output logic [POUT_W-1:0]     power_out_o,
  output logic                  sweep_down_o,
  output logic                  scan_done_o,
  output logic                  scanning_o
);

  logic [RANGE_W-1:0] range_q;
  logic [AVG_W-1:0]   avg_q;
  logic [GATE_W-1:0]  start_q, stop_q, step_q;
  cfg_t               cfg;

  dp_cmd_t cmd;
  dp_sts_t sts;
  res_t    res;
  res_t    out_q;
  logic    out_valid_q;
  logic    in_fire, out_free, load_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= '0;
      avg_q   <= AVG_RST;
      start_q <= START_RST;
      stop_q  <= STOP_RST;
      step_q  <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RANGE: range_q <= cfg_wdata_i[RANGE_W-1:0];
        REG_AVG:   avg_q   <= cfg_wdata_i[AVG_W-1:0];
        REG_START: start_q <= cfg_wdata_i[GATE_W-1:0];
        REG_STOP:  stop_q  <= cfg_wdata_i[GATE_W-1:0];
        REG_STEP:  step_q  <= cfg_wdata_i[GATE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero count and zero step act as one
  always_comb begin
    cfg.range_mode = range_q;
    cfg.avg        = (avg_q == '0) ? AVG_W'(1) : avg_q;
    cfg.gate_start = start_q;
    cfg.gate_stop  = stop_q;
    cfg.gate_step  = (step_q == '0) ? GATE_W'(1) : step_q;
  end

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  ivs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_ready_o (in_ready_o),
    .load_out_o (load_out)
  );

  ivs_dp #(
    .ADC_BITS (ADC_BITS),
    .DAC_BITS (DAC_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .opcode_i         (opcode_i),
    .voltage_sample_i (voltage_sample_i),
    .current_sample_i (current_sample_i),
    .sts_o            (sts),
    .res_o            (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dac_code_o    = out_q.dac_code;
  assign point_valid_o = out_q.point_valid;
  assign point_gate_o  = out_q.point_gate;
  assign voltage_out_o = out_q.voltage;
  assign current_out_o = out_q.current;
  assign power_out_o   = out_q.power;
  assign sweep_down_o  = out_q.sweep_down;
  assign scan_done_o   = out_q.scan_done;
  assign scanning_o    = out_q.scanning;

  // checks
  `IVS_ASSERT(a_busy_after_beat, clk_i, rst_ni, in_fire |=> !in_ready_o, "beat taken while busy")
  `IVS_ASSERT(a_load_when_free, clk_i, rst_ni, load_out |-> out_free, "result overwritten")
  `IVS_ASSERT(a_done_on_back_point, clk_i, rst_ni, out_valid_q && out_q.scan_done |-> out_q.point_valid && out_q.sweep_down && !out_q.scanning, "scan end not on backward point")
  `IVS_ASSERT_NEVER(a_point_ends_scan, clk_i, rst_ni, out_valid_q && out_q.point_valid && !out_q.scanning && !out_q.scan_done, "point left scan without done")

endmodule

/* dv/ivs_tb_pkg.sv */
// opcode codes of the sweep averager input beat, shared by the checker and the testbench top
package ivs_tb_pkg;

  typedef enum logic {
    OP_START  = 1'b0,
    OP_SAMPLE = 1'b1
  } ivs_op_e;

endpackage

/* dv/iv_curve_sweep_averager_checker.sv */
// sweep averager checker: predicts every result beat from the input beats and compares them
module iv_curve_sweep_averager_checker
  import ivs_pkg::*;
  import ivs_tb_pkg::*;
#(
  parameter int unsigned ADC_BITS = 12,
  parameter int unsigned DAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  opcode_i,
  input  logic [ADC_BITS-1:0]   voltage_sample_i,
  input  logic [ADC_BITS-1:0]   current_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [GATE_W-1:0]     dac_code_i,
  input  logic                  point_valid_i,
  input  logic [GATE_W-1:0]     point_gate_i,
  input  logic [VOUT_W-1:0]     voltage_out_i,
  input  logic [IOUT_W-1:0]     current_out_i,
  input  logic [POUT_W-1:0]     power_out_i,
  input  logic                  sweep_down_i,
  input  logic                  scan_done_i,
  input  logic                  scanning_i,
  output int unsigned           fail_count_o,
  output int unsigned           outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // calibration gains in q.16
  localparam longint unsigned VGAIN_CELL   = 72398;
  localparam longint unsigned VGAIN_MODULE = 357768;
  localparam longint unsigned VGAIN_ARRAY  = 7328544;
  localparam longint unsigned ROUND_HALF   = 64'd1 << (FRAC_W - 1);
  localparam longint unsigned VOUT_MAX     = (64'd1 << VOUT_W) - 1;
  localparam longint unsigned IOUT_MAX     = (64'd1 << IOUT_W) - 1;
  localparam longint unsigned POUT_MAX     = (64'd1 << POUT_W) - 1;
  localparam int unsigned     DAC_DROP     = GATE_W - DAC_BITS;

  // register copies
  logic [RANGE_W-1:0] range_q;
  logic [AVG_W-1:0]   avg_q;
  logic [GATE_W-1:0]  start_q;
  logic [GATE_W-1:0]  stop_q;
  logic [GATE_W-1:0]  step_q;

  // sweep state
  phase_e             phase_q;
  logic [GATE_W-1:0]  gate_q;
  logic [AVG_W-1:0]   pairs_q;
  logic [SUM_W-1:0]   vsum_q;
  logic [SUM_W-1:0]   isum_q;

  // predicted result beats, oldest first
  res_t sweep_points_q[$];

  function automatic logic [GATE_W-1:0] dac_drive(input logic [GATE_W-1:0] g);
    return (g >> DAC_DROP) << DAC_DROP;
  endfunction

  function automatic logic [SUM_W-1:0] sum_sat(input logic [SUM_W-1:0] s,
                                               input logic [ADC_BITS-1:0] x);
    int unsigned t;
    t = s + x;
    return (t > SUM_MAX) ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  // rounded mean of a sum scaled by a q.16 gain
  function automatic longint unsigned scaled_mean(input longint unsigned gain,
                                                  input longint unsigned sum,
                                                  input longint unsigned den);
    return (gain * sum + den / 2) / den;
  endfunction

  // apply one input beat to the sweep state and build its result beat
  function automatic res_t advance_sweep(input logic op, input logic [ADC_BITS-1:0] vs,
                                         input logic [ADC_BITS-1:0] cs);
    res_t              r;
    int unsigned       avg_eff;
    int unsigned       step_eff;
    int unsigned       nxt;
    longint unsigned   den;
    longint unsigned   vgain;
    longint unsigned   v;
    longint unsigned   i;
    longint unsigned   p;
    logic [GATE_W-1:0] measured;
    logic              down;
    logic              done;
    r = '0;
    avg_eff = (avg_q == 0) ? 1 : avg_q;
    step_eff = (step_q == 0) ? 1 : step_q;

    // start or restart drops any partial point
    if (op == OP_START) begin
      pairs_q = '0;
      vsum_q = '0;
      isum_q = '0;
      gate_q = start_q;
      phase_q = (start_q <= stop_q) ? PH_FWD : PH_IDLE;
      r.dac_code = dac_drive(gate_q);
      r.scanning = (phase_q != PH_IDLE);
      return r;
    end

    // samples outside a scan are ignored
    if (phase_q == PH_IDLE) begin
      r.dac_code = dac_drive(gate_q);
      return r;
    end

    vsum_q = sum_sat(vsum_q, vs);
    isum_q = sum_sat(isum_q, cs);
    pairs_q = pairs_q + 1'b1;
    if (pairs_q != 0 && pairs_q < avg_eff) begin
      r.dac_code = dac_drive(gate_q);
      r.scanning = 1'b1;
      return r;
    end

    // point complete: calibrate the means
    case (range_q)
      2'd0:    vgain = VGAIN_CELL;
      2'd1:    vgain = VGAIN_MODULE;
      default: vgain = VGAIN_ARRAY;
    endcase
    den = avg_eff;
    den = den << ADC_BITS;
    v = scaled_mean(vgain, vsum_q, den);
    i = scaled_mean(IGAIN_Q16, isum_q, den) + IOFFS_Q16;
    if (v > VOUT_MAX) v = VOUT_MAX;
    if (i > IOUT_MAX) i = IOUT_MAX;
    p = (v * i + ROUND_HALF) >> FRAC_W;
    if (p > POUT_MAX) p = POUT_MAX;

    // step the gate, turning at the stop code and ending at the start code
    measured = gate_q;
    down = (phase_q == PH_BWD);
    done = 1'b0;
    if (!down) begin
      nxt = gate_q + step_eff;
      if (nxt > stop_q) begin
        phase_q = PH_BWD;
        gate_q = stop_q;
      end else begin
        gate_q = nxt[GATE_W-1:0];
      end
    end else if (gate_q < start_q + step_eff) begin
      phase_q = PH_IDLE;
      done = 1'b1;
    end else begin
      gate_q = gate_q - step_eff[GATE_W-1:0];
    end
    pairs_q = '0;
    vsum_q = '0;
    isum_q = '0;

    r.dac_code = dac_drive(gate_q);
    r.point_valid = 1'b1;
    r.point_gate = measured;
    r.voltage = v[VOUT_W-1:0];
    r.current = i[IOUT_W-1:0];
    r.power = p[POUT_W-1:0];
    r.sweep_down = down;
    r.scan_done = done;
    r.scanning = (phase_q != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count_o++;
    end
  endfunction

  // watch register writes, input beats and result beats
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      range_q = '0;
      avg_q = AVG_RST;
      start_q = START_RST;
      stop_q = STOP_RST;
      step_q = STEP_RST;
      phase_q = PH_IDLE;
      gate_q = '0;
      pairs_q = '0;
      vsum_q = '0;
      isum_q = '0;
      sweep_points_q.delete();
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_RANGE: range_q = cfg_wdata_i[RANGE_W-1:0];
          REG_AVG:   avg_q = cfg_wdata_i[AVG_W-1:0];
          REG_START: start_q = cfg_wdata_i[GATE_W-1:0];
          REG_STOP:  stop_q = cfg_wdata_i[GATE_W-1:0];
          REG_STEP:  step_q = cfg_wdata_i[GATE_W-1:0];
          default: ;
        endcase
      end

      // input beat
      if (in_valid_i && in_ready_i)
        sweep_points_q.push_back(advance_sweep(opcode_i, voltage_sample_i, current_sample_i));

      // result beat against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (sweep_points_q.size() == 0) begin
          $error("result beat with no input beat pending");
          fail_count_o++;
        end else begin
          want = sweep_points_q.pop_front();
          check_field("dac_code", want.dac_code, dac_code_i);
          check_field("point_valid", want.point_valid, point_valid_i);
          check_field("point_gate", want.point_gate, point_gate_i);
          check_field("voltage_out", want.voltage, voltage_out_i);
          check_field("current_out", want.current, current_out_i);
          check_field("power_out", want.power, power_out_i);
          check_field("sweep_down", want.sweep_down, sweep_down_i);
          check_field("scan_done", want.scan_done, scan_done_i);
          check_field("scanning", want.scanning, scanning_i);
        end
      end
    end
    outstanding_o = sweep_points_q.size();
  end

endmodule

/* dv/tb_iv_curve_sweep_averager_unit.sv */
// testbench top for the sweep averager: stimulus, result-side stalls and the verdict
module tb_iv_curve_sweep_averager_unit
  import ivs_pkg::*, ivs_tb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADC_BITS      = 12;
  localparam int unsigned DAC_BITS      = 16;
  localparam int unsigned SAMPLE_MAX    = (1 << ADC_BITS) - 1;
  localparam int unsigned GATE_MAX      = (1 << GATE_W) - 1;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 120;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  opcode = OP_START;
  logic [ADC_BITS-1:0]   vs = '0;
  logic [ADC_BITS-1:0]   cs = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [GATE_W-1:0]     dac_code;
  logic                  point_valid;
  logic [GATE_W-1:0]     point_gate;
  logic [VOUT_W-1:0]     voltage_out;
  logic [IOUT_W-1:0]     current_out;
  logic [POUT_W-1:0]     power_out;
  logic                  sweep_down;
  logic                  scan_done;
  logic                  scanning;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_req = 0;
  int unsigned beats_sent = 0;
  bit          scan_cut = 1'b0;

  iv_curve_sweep_averager_unit #(
    .ADC_BITS(ADC_BITS),
    .DAC_BITS(DAC_BITS)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .opcode_i        (opcode),
    .voltage_sample_i(vs),
    .current_sample_i(cs),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .dac_code_o      (dac_code),
    .point_valid_o   (point_valid),
    .point_gate_o    (point_gate),
    .voltage_out_o   (voltage_out),
    .current_out_o   (current_out),
    .power_out_o     (power_out),
    .sweep_down_o    (sweep_down),
    .scan_done_o     (scan_done),
    .scanning_o      (scanning)
  );

  iv_curve_sweep_averager_checker #(
    .ADC_BITS(ADC_BITS),
    .DAC_BITS(DAC_BITS)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .opcode_i        (opcode),
    .voltage_sample_i(vs),
    .current_sample_i(cs),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .dac_code_i      (dac_code),
    .point_valid_i   (point_valid),
    .point_gate_i    (point_gate),
    .voltage_out_i   (voltage_out),
    .current_out_i   (current_out),
    .power_out_i     (power_out),
    .sweep_down_i    (sweep_down),
    .scan_done_i     (scan_done),
    .scanning_i      (scanning),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding)
  );

  // 2 ns clock
  always #1 clk = ~clk;

  // result side ready, random stalls plus an occasional long hold-off
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one input beat after a random gap and wait until it is taken
  task automatic send_beat(input logic op, input logic [ADC_BITS-1:0] v,
                           input logic [ADC_BITS-1:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    vs <= v;
    cs <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending until every predicted result beat has come back
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  // program all registers with the block quiet
  task automatic apply_settings(input int unsigned rng, input int unsigned avg,
                                input int unsigned start, input int unsigned stop,
                                input int unsigned step);
    wait_results_drained();
    write_reg(REG_RANGE, rng);
    write_reg(REG_AVG, avg);
    write_reg(REG_START, start);
    write_reg(REG_STOP, stop);
    write_reg(REG_STEP, step);
    cfg_we <= 1'b0;
  endtask

  // adc code with extra weight on the rails
  function automatic logic [ADC_BITS-1:0] pick_sample();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom_range(0, SAMPLE_MAX);
  endfunction

  // one scan with random settings, mostly run to the end, sometimes cut short
  task automatic random_scan(input bit hold_off);
    int unsigned rng;
    int unsigned avg;
    int unsigned avg_eff;
    int unsigned start;
    int unsigned stop;
    int unsigned step;
    int unsigned step_eff;
    int unsigned per_dir;
    int unsigned points;
    int unsigned n_pairs;
    int unsigned pick;
    bit          resume;
    rng = $urandom_range(0, 3);
    pick = $urandom_range(0, 99);
    if (pick < 3) avg = 0;
    else if (pick < 4) avg = $urandom_range(100, 255);
    else avg = $urandom_range(1, 4);
    avg_eff = (avg == 0) ? 1 : avg;
    pick = $urandom_range(0, 99);
    if (pick < 3) step = 0;
    else if (pick < 20) step = $urandom_range(0, GATE_MAX);
    else step = $urandom_range(1, 3000);
    step_eff = (step == 0) ? 1 : step;
    per_dir = (avg_eff > 4) ? 1 : $urandom_range(1, 4);
    start = $urandom_range(0, GATE_MAX);
    if ($urandom_range(0, 99) < 5) begin
      // empty scan, start code above stop code
      if (start == 0) start = 1;
      stop = $urandom_range(0, start - 1);
    end else begin
      stop = start + (per_dir - 1) * step_eff + $urandom_range(0, step_eff - 1);
      if (stop > GATE_MAX) stop = GATE_MAX;
    end
    points = (start > stop) ? 0 : 2 * ((stop - start) / step_eff + 1);
    n_pairs = points * avg_eff;
    resume = scan_cut && !hold_off && ($urandom_range(0, 99) < 30);

    apply_settings(rng, avg, start, stop, step);
    if (hold_off) hold_req = HOLD_CYCLES;

    if (resume) begin
      // carry on with the interrupted scan under the new settings
      n_pairs = $urandom_range(1, 8);
      scan_cut = 1'b0;
    end else begin
      send_beat(OP_START, pick_sample(), pick_sample());
      beats_sent++;
      scan_cut = !hold_off && (n_pairs != 0) && ($urandom_range(0, 99) < 15);
      if (scan_cut) n_pairs = $urandom_range(0, n_pairs - 1);
    end
    repeat (n_pairs) begin
      send_beat(OP_SAMPLE, pick_sample(), pick_sample());
      beats_sent++;
    end

    // stray samples once the scan is over
    if (hold_off || (!resume && !scan_cut && $urandom_range(0, 99) < 20)) begin
      repeat (2) send_beat(OP_SAMPLE, pick_sample(), pick_sample());
    end
  endtask

  initial begin : stimulus
    send_idle_pct = 25;
    recv_idle_pct = 78;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // samples before any start, then a start on the reset settings
    send_beat(OP_SAMPLE, '0, '0);
    send_beat(OP_SAMPLE, '1, '1);
    send_beat(OP_START, '0, '0);
    send_beat(OP_SAMPLE, '1, '0);
    send_beat(OP_SAMPLE, '0, '1);

    // top of the gate range, widest step, one pair per point
    apply_settings(0, 1, GATE_MAX - 1, GATE_MAX, GATE_MAX);
    send_beat(OP_START, '1, '1);
    send_beat(OP_SAMPLE, '1, '1);
    send_beat(OP_SAMPLE, '1, '0);
    send_beat(OP_SAMPLE, 12'd1, 12'd1);

    // range three, zero averaging count and zero step from gate code zero
    apply_settings(3, 0, 0, 1, 0);
    send_beat(OP_START, '0, '0);
    send_beat(OP_SAMPLE, '1, '1);
    send_beat(OP_SAMPLE, '0, '0);
    send_beat(OP_SAMPLE, pick_sample(), pick_sample());
    send_beat(OP_SAMPLE, pick_sample(), pick_sample());

    // restart inside a point, then lower the count mid point
    apply_settings(2, 3, 100, 120, 10);
    send_beat(OP_START, '0, '0);
    send_beat(OP_SAMPLE, '1, '1);
    send_beat(OP_SAMPLE, 12'd2048, 12'd1024);
    send_beat(OP_START, '1, '1);
    send_beat(OP_SAMPLE, '1, '1);
    send_beat(OP_SAMPLE, 12'd3000, 12'd4000);
    apply_settings(1, 1, 100, 120, 10);
    send_beat(OP_SAMPLE, '1, '1);

    // start code above stop code leaves the block idle
    apply_settings(0, 255, 10, 5, 7);
    send_beat(OP_START, '0, '0);
    send_beat(OP_SAMPLE, '1, '1);

    // random scans under three stall mixes
    while (beats_sent < 500) random_scan(1'b0);
    send_idle_pct = 78;
    recv_idle_pct = 25;
    while (beats_sent < 1000) random_scan(1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_scan(1'b1);
    while (beats_sent < 1500) random_scan(1'b0);

    // let the last results out, then give the verdict
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run time limit
  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* iv_curve_sweep_averager_unit.f */
+incdir+src
src/ivs_pkg.sv
src/ivs_div.sv
src/ivs_dp.sv
src/ivs_ctrl.sv
src/iv_curve_sweep_averager_unit.sv
dv/ivs_tb_pkg.sv
dv/iv_curve_sweep_averager_checker.sv
dv/tb_iv_curve_sweep_averager_unit.sv
